>>> design/sli_pkg.sv
// shared types and constants for the sorted list core
package sli_pkg;

    localparam int VALUE_W = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_DROPPED  = 3'd1;
    localparam logic [2:0] ST_DELETED  = 3'd2;
    localparam logic [2:0] ST_ENTRY    = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [1:0]                 op;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [2:0]                 status;
        logic [4:0]                 removed_count;
        logic                       is_last;
    } t_out_item;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic                       ins;
        logic                       del;
        logic                       rot;
        logic signed [VALUE_W-1:0] key;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_DELETE,
        S_DUMP
    } t_state;

endpackage

>>> design/sorted_list_insert_delete_core.sv
// top level: sorted list of signed Q16.16 values held in a chain of cells
//
// Input: an item {op, value} transfers at a rising edge with i_start high and
// o_busy low. op insert places value in ascending order, delete removes all
// entries equal to value, dump walks the list out in ascending order.
// Output: each result is shown for one cycle with o_strobe high; the last
// result of an item has is_last set. The receiver cannot stall the block.
// Sequence, counted from the accepting edge:
//   insert: dropped when full, else one chain update; result registered with it
//   delete: one cell shift per cycle while a match remains, then the result
//   dump:   one entry per cycle off the head cell while the chain rotates
//   empty dump: result straight from idle; unused op code: no result
// The rate is set by the chain moving entries one neighbor step per cycle.
// Reset (synchronous, active low) marks every cell empty and the count zero.
module sorted_list_insert_delete_core #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  sli_pkg::t_in_item  i_item,
    output logic               o_busy,
    output logic               o_strobe,
    output sli_pkg::t_out_item o_result
);

    sli_pkg::t_cell_ctl                  w_ctl;
    logic signed [sli_pkg::VALUE_W-1:0] w_val   [CAPACITY];
    logic                                w_valid [CAPACITY];
    logic                                w_take  [CAPACITY];
    logic [CAPACITY-1:0]                 w_eq;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [sli_pkg::VALUE_W-1:0] w_lv;
            logic                                w_lvalid;
            logic                                w_ltake;
            logic signed [sli_pkg::VALUE_W-1:0] w_rv;
            logic                                w_rvalid;
            logic                                w_eq_bit;

            if (gi == 0) begin : g_first
                assign w_lv     = '0;
                assign w_lvalid = 1'b1;
                assign w_ltake  = 1'b0;
            end else begin : g_mid_l
                assign w_lv     = w_val[gi-1];
                assign w_lvalid = w_valid[gi-1];
                assign w_ltake  = w_take[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign w_rv     = '0;
                assign w_rvalid = 1'b0;
            end else begin : g_mid_r
                assign w_rv     = w_val[gi+1];
                assign w_rvalid = w_valid[gi+1];
            end

            sli_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_left_val    (w_lv),
                .i_left_valid  (w_lvalid),
                .i_left_take   (w_ltake),
                .i_right_val   (w_rv),
                .i_right_valid (w_rvalid),
                .i_head_val    (w_val[0]),
                .o_val         (w_val[gi]),
                .o_valid       (w_valid[gi]),
                .o_take        (w_take[gi]),
                .o_eq          (w_eq_bit)
            );

            assign w_eq[gi] = w_eq_bit;
        end
    endgenerate

    sli_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (i_item),
        .i_any_match (|w_eq),
        .i_head_val  (w_val[0]),
        .o_ctl       (w_ctl),
        .o_busy      (o_busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

>>> design/sli_cell.sv
// one cell of the sorted chain: holds an entry and trades it with its neighbors
module sli_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sli_pkg::t_cell_ctl                   i_ctl,
    input  logic signed [sli_pkg::VALUE_W-1:0]  i_left_val,
    input  logic                                 i_left_valid,
    input  logic                                 i_left_take,
    input  logic signed [sli_pkg::VALUE_W-1:0]  i_right_val,
    input  logic                                 i_right_valid,
    input  logic signed [sli_pkg::VALUE_W-1:0]  i_head_val,
    output logic signed [sli_pkg::VALUE_W-1:0]  o_val,
    output logic                                 o_valid,
    output logic                                 o_take,
    output logic                                 o_eq
);

    logic signed [sli_pkg::VALUE_W-1:0] r_val;
    logic signed [sli_pkg::VALUE_W-1:0] n_val;
    logic                                r_valid;
    logic                                n_valid;
    logic                                w_gt;
    logic                                w_ge;

    assign w_gt    = r_valid && (r_val > i_ctl.key);
    assign w_ge    = r_valid && (r_val >= i_ctl.key);
    assign o_take  = w_gt || !r_valid;
    assign o_eq    = r_valid && (r_val == i_ctl.key);
    assign o_val   = r_val;
    assign o_valid = r_valid;

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_ctl.ins) begin
            // left neighbor moving right wins over the new key
            if (i_left_take) begin
                n_val = i_left_val;
            end else if (o_take) begin
                n_val = i_ctl.key;
            end
            n_valid = r_valid || i_left_valid;
        end else if (i_ctl.del) begin
            // drop the first matching entry, everything above slides left
            if (w_ge || !r_valid) begin
                n_val   = i_right_val;
                n_valid = i_right_valid;
            end
        end else if (i_ctl.rot) begin
            // rotate the valid prefix by one so the head walks through all entries
            if (r_valid) begin
                n_val = i_right_valid ? i_right_val : i_head_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_val <= n_val;
    end

endmodule

>>> design/sli_ctrl.sv
// sequencer: decodes commands, drives the cell chain and builds results
module sli_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  sli_pkg::t_in_item                    i_item,
    input  logic                                 i_any_match,
    input  logic signed [sli_pkg::VALUE_W-1:0]  i_head_val,
    output sli_pkg::t_cell_ctl                   o_ctl,
    output logic                                 o_busy,
    output logic                                 o_strobe,
    output sli_pkg::t_out_item                   o_result
);

    localparam int CW = $clog2(CAPACITY + 1);

    sli_pkg::t_state                     r_state;
    sli_pkg::t_state                     n_state;
    logic signed [sli_pkg::VALUE_W-1:0] r_key;
    logic signed [sli_pkg::VALUE_W-1:0] n_key;
    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       n_count;
    logic [CW-1:0]                       r_rem;
    logic [CW-1:0]                       n_rem;
    logic                                r_strobe;
    logic                                n_strobe;
    sli_pkg::t_out_item                  r_result;
    sli_pkg::t_out_item                  n_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sli_pkg::S_IDLE;
            r_count  <= '0;
            r_rem    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rem    <= n_rem;
            r_strobe <= n_strobe;
        end
        r_key    <= n_key;
        r_result <= n_result;
    end

    always_comb begin
        n_state  = r_state;
        n_key    = r_key;
        n_count  = r_count;
        n_rem    = r_rem;
        n_strobe = 1'b0;
        n_result = '0;
        o_ctl     = '0;
        o_ctl.key = r_key;
        case (r_state)
            sli_pkg::S_IDLE: begin
                if (i_start) begin
                    n_key = i_item.value;
                    case (i_item.op)
                        sli_pkg::OP_INSERT: begin
                            n_state = sli_pkg::S_INSERT;
                        end
                        sli_pkg::OP_DELETE: begin
                            n_state = sli_pkg::S_DELETE;
                            n_rem   = '0;
                        end
                        sli_pkg::OP_DUMP: begin
                            if (r_count == '0) begin
                                n_strobe         = 1'b1;
                                n_result.status  = sli_pkg::ST_EMPTY;
                                n_result.is_last = 1'b1;
                            end else begin
                                n_state = sli_pkg::S_DUMP;
                                n_rem   = r_count;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sli_pkg::S_INSERT: begin
                n_strobe         = 1'b1;
                n_result.is_last = 1'b1;
                if (r_count == CW'(CAPACITY)) begin
                    n_result.status = sli_pkg::ST_DROPPED;
                end else begin
                    o_ctl.ins       = 1'b1;
                    n_count         = r_count + 1'b1;
                    n_result.status = sli_pkg::ST_INSERTED;
                end
                n_state = sli_pkg::S_IDLE;
            end
            sli_pkg::S_DELETE: begin
                // one matching entry leaves per cycle
                if (i_any_match) begin
                    o_ctl.del = 1'b1;
                    n_rem     = r_rem + 1'b1;
                    n_count   = r_count - 1'b1;
                end else begin
                    n_strobe               = 1'b1;
                    n_result.status        = sli_pkg::ST_DELETED;
                    n_result.removed_count = 5'(r_rem);
                    n_result.is_last       = 1'b1;
                    n_state                = sli_pkg::S_IDLE;
                end
            end
            sli_pkg::S_DUMP: begin
                o_ctl.rot             = 1'b1;
                n_strobe              = 1'b1;
                n_result.result_value = i_head_val;
                n_result.status       = sli_pkg::ST_ENTRY;
                n_result.is_last      = (r_rem == CW'(1));
                n_rem                 = r_rem - 1'b1;
                if (r_rem == CW'(1)) begin
                    n_state = sli_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sli_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != sli_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_insert_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sli_pkg::S_INSERT) |=> (r_strobe && r_result.is_last))
        else $error("insert did not give a final result");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.status == sli_pkg::ST_INSERTED) |->
            (r_count == $past(r_count) + 1'b1))
        else $error("insert transfer without count step");

    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sli_pkg::S_DUMP && r_rem == CW'(1)) |=>
            (r_state == sli_pkg::S_IDLE && r_result.is_last))
        else $error("dump did not end on its last entry");

endmodule

>>> tb/sorted_list_checker.sv
`timescale 1ns / 1ps
// checker for the sorted list core: tracks the list, predicts results, compares them
module sorted_list_checker #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  sli_pkg::t_in_item  i_item,
    input  logic               i_strobe,
    input  sli_pkg::t_out_item i_result,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic signed [sli_pkg::VALUE_W-1:0] shadow_list [CAPACITY];
    int                                 shadow_count;
    sli_pkg::t_out_item                 expected_results [$];
    int                                 fail_count;

    function automatic sli_pkg::t_out_item make_result(
        input logic [sli_pkg::VALUE_W-1:0] val,
        input logic [2:0]                  st,
        input logic [4:0]                  cnt,
        input logic                        last);
        sli_pkg::t_out_item r;
        r.result_value  = val;
        r.status        = st;
        r.removed_count = cnt;
        r.is_last       = last;
        return r;
    endfunction

    // updates the shadow list and queues what the core should answer
    function automatic void apply_list_op(input sli_pkg::t_in_item it);
        int pos;
        int kept;
        int removed;
        logic signed [sli_pkg::VALUE_W-1:0] key;
        key = $signed(it.value);
        case (it.op)
            sli_pkg::OP_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    expected_results.push_back(
                        make_result('0, sli_pkg::ST_DROPPED, '0, 1'b1));
                end else begin
                    pos = 0;
                    // equal values go behind the ones already stored
                    while (pos < shadow_count && shadow_list[pos] <= key)
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = key;
                    shadow_count++;
                    expected_results.push_back(
                        make_result('0, sli_pkg::ST_INSERTED, '0, 1'b1));
                end
            end
            sli_pkg::OP_DELETE: begin
                kept = 0;
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_list[i] != key) begin
                        shadow_list[kept] = shadow_list[i];
                        kept++;
                    end
                end
                removed      = shadow_count - kept;
                shadow_count = kept;
                expected_results.push_back(
                    make_result('0, sli_pkg::ST_DELETED, removed[4:0], 1'b1));
            end
            sli_pkg::OP_DUMP: begin
                if (shadow_count == 0) begin
                    expected_results.push_back(
                        make_result('0, sli_pkg::ST_EMPTY, '0, 1'b1));
                end else begin
                    for (int i = 0; i < shadow_count; i++)
                        expected_results.push_back(
                            make_result(shadow_list[i], sli_pkg::ST_ENTRY, '0,
                                        i == shadow_count - 1));
                end
            end
            default: begin
                // unused op code: no state change, no result
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        sli_pkg::t_out_item want;
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            // results first: a result never belongs to an item taken at the same edge
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result value %0d status %0d removed %0d last %0d",
                             $time, $signed(i_result.result_value), i_result.status,
                             i_result.removed_count, i_result.is_last);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.result_value !== want.result_value) begin
                        $display("%0t: result_value expected %0d actual %0d", $time,
                                 $signed(want.result_value), $signed(i_result.result_value));
                        fail_count++;
                    end
                    if (i_result.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, i_result.status);
                        fail_count++;
                    end
                    if (i_result.removed_count !== want.removed_count) begin
                        $display("%0t: removed_count expected %0d actual %0d", $time,
                                 want.removed_count, i_result.removed_count);
                        fail_count++;
                    end
                    if (i_result.is_last !== want.is_last) begin
                        $display("%0t: is_last expected %0d actual %0d", $time,
                                 want.is_last, i_result.is_last);
                        fail_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                apply_list_op(i_item);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// testbench top: drives the sorted list core with directed and random commands
module tb_top;

    localparam int CAPACITY       = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 25;
    localparam int TAIL_CYCLES    = 40;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum int {
        PH_FILL,
        PH_MIXED,
        PH_DRAIN
    } t_phase_kind;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    sli_pkg::t_in_item  item = '0;
    logic               busy;
    logic               strobe;
    sli_pkg::t_out_item result;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    logic [31:0]        value_pool [6];

    always #2 clk = ~clk;

    sorted_list_insert_delete_core #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_start  (start),
        .i_item   (item),
        .o_busy   (busy),
        .o_strobe (strobe),
        .o_result (result)
    );

    sorted_list_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_strobe     (strobe),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog: cycles with no transfer on either side
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // called after the clock rises; returns right after the accepting edge
    task automatic send_op(input logic [1:0] op_code, input logic [31:0] val);
        item  <= sli_pkg::t_in_item'{op: op_code, value: val};
        start <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return value_pool[$urandom_range(0, 5)];
        if (r < 65) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [1:0] pick_op(input t_phase_kind kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            PH_FILL: begin
                if (r < 85) return sli_pkg::OP_INSERT;
                if (r < 97) return sli_pkg::OP_DUMP;
                return OP_UNUSED;
            end
            PH_DRAIN: begin
                if (r < 25) return sli_pkg::OP_INSERT;
                if (r < 80) return sli_pkg::OP_DELETE;
                if (r < 97) return sli_pkg::OP_DUMP;
                return OP_UNUSED;
            end
            default: begin
                if (r < 50) return sli_pkg::OP_INSERT;
                if (r < 75) return sli_pkg::OP_DELETE;
                if (r < 96) return sli_pkg::OP_DUMP;
                return OP_UNUSED;
            end
        endcase
    endfunction

    task automatic refresh_pool();
        for (int i = 0; i < 6; i++) begin
            // small whole numbers collide often, full words cover every bit
            if (i < 3)
                value_pool[i] = ($urandom_range(0, 15) - 8) << 16;
            else
                value_pool[i] = $urandom();
        end
    endtask

    initial begin
        t_phase_kind kind;
        logic [1:0]  op_code;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty store, extremes, duplicates, unused op code
        send_op(sli_pkg::OP_DUMP,   32'h0);          idle_for(gap_length());
        send_op(sli_pkg::OP_DELETE, 32'h0);          idle_for(gap_length());
        send_op(OP_UNUSED,          32'hFFFF_FFFF);  idle_for(gap_length());
        send_op(sli_pkg::OP_INSERT, 32'h7FFF_FFFF);  idle_for(gap_length());
        send_op(sli_pkg::OP_INSERT, 32'h8000_0000);  idle_for(gap_length());
        send_op(sli_pkg::OP_INSERT, 32'h0000_0000);  idle_for(gap_length());
        send_op(sli_pkg::OP_INSERT, 32'hFFFF_FFFF);  idle_for(gap_length());
        send_op(sli_pkg::OP_INSERT, 32'h0001_0000);  idle_for(gap_length());
        send_op(sli_pkg::OP_INSERT, 32'h0000_0000);  idle_for(gap_length());
        send_op(sli_pkg::OP_DUMP,   32'hFFFF_FFFF);  idle_for(gap_length());
        send_op(sli_pkg::OP_DELETE, 32'h0000_0000);  idle_for(gap_length());
        send_op(sli_pkg::OP_DELETE, 32'h1234_5678);  idle_for(gap_length());
        send_op(sli_pkg::OP_DUMP,   32'h0);          idle_for(gap_length());
        send_op(sli_pkg::OP_DELETE, 32'h7FFF_FFFF);  idle_for(gap_length());
        send_op(sli_pkg::OP_DELETE, 32'h8000_0000);  idle_for(gap_length());
        send_op(sli_pkg::OP_DUMP,   32'h0);
        drain_results();

        // random phases: filling overflows the store, draining deletes pool values
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            refresh_pool();
            case (ph % 4)
                0:       kind = PH_FILL;
                2:       kind = PH_DRAIN;
                default: kind = PH_MIXED;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op_code = pick_op(kind);
                send_op(op_code, pick_value());
                // phase 3 runs back to back; the drain below follows the last item
                if (ph != 3 && n != PHASE_ITEMS - 1)
                    idle_for(gap_length());
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
